// ----- hw/rtl/sfp_pkg.sv -----
// ----------------------------------------------------------------------------
// sfp_pkg
// Types and constants shared by the sensor frame parser modules.
// ----------------------------------------------------------------------------
package sfp_pkg;

  localparam int SAMPLE_BYTES = 16;
  localparam int STORE_AW     = $clog2(SAMPLE_BYTES);

  // reset values of the configuration registers
  localparam logic [7:0]  SYNC_FIRST_RST  = 8'hC9;
  localparam logic [7:0]  SYNC_SECOND_RST = 8'h9C;
  localparam logic [7:0]  SAMPLE_ID_RST   = 8'h01;
  localparam logic [15:0] MAX_SKIP_RST    = 16'd1024;

  typedef enum logic [1:0] {
    CFG_SYNC_FIRST  = 2'd0,
    CFG_SYNC_SECOND = 2'd1,
    CFG_SAMPLE_ID   = 2'd2,
    CFG_MAX_SKIP    = 2'd3
  } cfg_index_t;

  typedef enum logic [2:0] {
    PH_SYNC1 = 3'd0,
    PH_SYNC2 = 3'd1,
    PH_ID    = 3'd2,
    PH_LEN1  = 3'd3,
    PH_LEN2  = 3'd4,
    PH_DATA  = 3'd5,
    PH_CKA   = 3'd6,
    PH_CKB   = 3'd7
  } phase_t;

  typedef enum logic [1:0] {
    ST_INCOMPLETE  = 2'd0,
    ST_DECODED     = 2'd1,
    ST_MISMATCH    = 2'd2,
    ST_UNSUPPORTED = 2'd3
  } status_t;

  typedef struct packed {
    logic [7:0]  sync_first;
    logic [7:0]  sync_second;
    logic [7:0]  sample_id;
    logic [15:0] max_skip;
  } cfg_t;

  typedef struct packed {
    logic                en;
    logic [STORE_AW-1:0] addr;
    logic [7:0]          data;
  } store_wr_t;

endpackage

// ----- hw/rtl/sfp_parser.sv -----
// ----------------------------------------------------------------------------
// sfp_parser
// Frame state machine with Fletcher-8 sums; one byte per step.
// ----------------------------------------------------------------------------
module sfp_parser import sfp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  logic [7:0] rx_byte,
  input  cfg_t       cfg,
  output status_t    status,
  output store_wr_t  store_wr
);

  phase_t      phase, phase_next;
  logic [7:0]  frame_id, frame_id_next;
  logic [15:0] frame_length, frame_length_next;
  logic [15:0] payload_count, payload_count_next;
  logic [7:0]  sum_a, sum_a_next;
  logic [7:0]  sum_b, sum_b_next;

  logic [7:0]  add_a;
  logic [7:0]  add_b;
  logic [15:0] len_full;
  logic [15:0] count_inc;
  logic        is_sample;

  assign add_a     = sum_a + rx_byte;
  assign add_b     = sum_b + add_a;
  assign len_full  = {rx_byte, frame_length[7:0]};
  assign count_inc = payload_count + 16'd1;
  assign is_sample = (frame_id == cfg.sample_id);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_SYNC1;
      frame_id      <= '0;
      frame_length  <= '0;
      payload_count <= '0;
      sum_a         <= '0;
      sum_b         <= '0;
    end else if (step) begin
      phase         <= phase_next;
      frame_id      <= frame_id_next;
      frame_length  <= frame_length_next;
      payload_count <= payload_count_next;
      sum_a         <= sum_a_next;
      sum_b         <= sum_b_next;
    end
  end

  always_comb begin
    phase_next         = phase;
    frame_id_next      = frame_id;
    frame_length_next  = frame_length;
    payload_count_next = payload_count;
    sum_a_next         = sum_a;
    sum_b_next         = sum_b;
    status             = ST_INCOMPLETE;
    store_wr.en        = 1'b0;
    store_wr.addr      = payload_count[STORE_AW-1:0];
    store_wr.data      = rx_byte;

    unique case (phase)
      PH_SYNC1: begin
        if (rx_byte == cfg.sync_first) phase_next = PH_SYNC2;
      end
      PH_SYNC2: begin
        if (rx_byte == cfg.sync_second) begin
          sum_a_next = '0;
          sum_b_next = '0;
          phase_next = PH_ID;
        end else if (rx_byte == cfg.sync_first) begin
          phase_next = PH_SYNC2;
        end else begin
          phase_next = PH_SYNC1;
        end
      end
      PH_ID: begin
        frame_id_next = rx_byte;
        sum_a_next    = add_a;
        sum_b_next    = add_b;
        phase_next    = PH_LEN1;
      end
      PH_LEN1: begin
        frame_length_next = {8'h00, rx_byte};
        sum_a_next        = add_a;
        sum_b_next        = add_b;
        phase_next        = PH_LEN2;
      end
      PH_LEN2: begin
        frame_length_next = len_full;
        sum_a_next        = add_a;
        sum_b_next        = add_b;
        // wrong sample length or oversized skip frame: drop silently
        if ((is_sample && len_full != 16'(SAMPLE_BYTES)) ||
            (!is_sample && len_full > cfg.max_skip)) begin
          phase_next         = PH_SYNC1;
          frame_id_next      = '0;
          frame_length_next  = '0;
          payload_count_next = '0;
          sum_a_next         = '0;
          sum_b_next         = '0;
        end else begin
          payload_count_next = '0;
          phase_next         = (len_full == 16'd0) ? PH_CKA : PH_DATA;
        end
      end
      PH_DATA: begin
        sum_a_next         = add_a;
        sum_b_next         = add_b;
        store_wr.en        = is_sample && (payload_count < 16'(SAMPLE_BYTES));
        payload_count_next = count_inc;
        if (count_inc == frame_length) phase_next = PH_CKA;
      end
      PH_CKA: begin
        if (rx_byte != sum_a) begin
          status             = ST_MISMATCH;
          phase_next         = PH_SYNC1;
          frame_id_next      = '0;
          frame_length_next  = '0;
          payload_count_next = '0;
          sum_a_next         = '0;
          sum_b_next         = '0;
        end else begin
          phase_next = PH_CKB;
        end
      end
      PH_CKB: begin
        if (rx_byte != sum_b) status = ST_MISMATCH;
        else if (!is_sample)  status = ST_UNSUPPORTED;
        else                  status = ST_DECODED;
        phase_next         = PH_SYNC1;
        frame_id_next      = '0;
        frame_length_next  = '0;
        payload_count_next = '0;
        sum_a_next         = '0;
        sum_b_next         = '0;
      end
      default: phase_next = PH_SYNC1;
    endcase

    if (!step) store_wr.en = 1'b0;
  end

endmodule

// ----- hw/rtl/sfp_store.sv -----
// ----------------------------------------------------------------------------
// sfp_store
// Sample payload bytes and their little-endian field decode.
// ----------------------------------------------------------------------------
module sfp_store import sfp_pkg::*; (
  input  logic               clk,
  input  store_wr_t          store_wr,
  output logic signed [31:0] range_val,
  output logic [31:0]        status_word,
  output logic [63:0]        timestamp
);

  logic [7:0] mem [SAMPLE_BYTES];

  always_ff @(posedge clk) begin
    if (store_wr.en) mem[store_wr.addr] <= store_wr.data;
  end

  assign range_val   = {mem[3], mem[2], mem[1], mem[0]};
  assign status_word = {mem[7], mem[6], mem[5], mem[4]};
  assign timestamp   = {mem[15], mem[14], mem[13], mem[12],
                        mem[11], mem[10], mem[9],  mem[8]};

endmodule

// ----- hw/rtl/sensor_frame_parser_fletcher_top.sv -----
// ----------------------------------------------------------------------------
// sensor_frame_parser_fletcher_top
// Sync-framed byte stream parser with Fletcher-8 check. Takes one rx_byte
// per transaction and returns exactly one result per byte: status 0 while a
// frame is in progress, 1 for a good sample frame (range, status word and
// timestamp decoded little-endian from its 16 payload bytes), 2 for a bad
// check byte, 3 for a good frame of another id. Throughput is one byte per
// clock while the result register is free or draining. A byte is taken into
// the input register, then the state update and sums load its result into
// the result register once that register is free or draining; a held result
// keeps the next byte waiting in the input register.
// Configuration registers must be written through cfg_wr_en/cfg_index/
// cfg_wr_data while the parser is idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module sensor_frame_parser_fletcher_top import sfp_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_wr_data,
  input  logic               rx_valid,
  output logic               rx_ready,
  input  logic [7:0]         rx_byte,
  output logic               res_valid,
  input  logic               res_ready,
  output logic [1:0]         parse_status,
  output logic signed [31:0] sample_range,
  output logic [31:0]        sample_status_word,
  output logic [63:0]        sample_timestamp
);

  cfg_t       cfg;
  logic       s0_valid;
  logic [7:0] s0_byte;
  logic       advance;

  status_t            status;
  store_wr_t          store_wr;
  logic signed [31:0] dec_range;
  logic [31:0]        dec_status_word;
  logic [63:0]        dec_timestamp;
  logic               decoded;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sync_first  <= SYNC_FIRST_RST;
      cfg.sync_second <= SYNC_SECOND_RST;
      cfg.sample_id   <= SAMPLE_ID_RST;
      cfg.max_skip    <= MAX_SKIP_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_SYNC_FIRST:  cfg.sync_first  <= cfg_wr_data[7:0];
        CFG_SYNC_SECOND: cfg.sync_second <= cfg_wr_data[7:0];
        CFG_SAMPLE_ID:   cfg.sample_id   <= cfg_wr_data[7:0];
        CFG_MAX_SKIP:    cfg.max_skip    <= cfg_wr_data;
        default: ;
      endcase
    end
  end

  // input register moves on whenever the result slot is free or draining
  assign advance  = s0_valid && (!res_valid || res_ready);
  assign rx_ready = !s0_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (rx_ready) begin
      s0_valid <= rx_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rx_valid && rx_ready) s0_byte <= rx_byte;
  end

  sfp_parser u_parser (
    .clk      (clk),
    .rst      (rst),
    .step     (advance),
    .rx_byte  (s0_byte),
    .cfg      (cfg),
    .status   (status),
    .store_wr (store_wr)
  );

  sfp_store u_store (
    .clk         (clk),
    .store_wr    (store_wr),
    .range_val   (dec_range),
    .status_word (dec_status_word),
    .timestamp   (dec_timestamp)
  );

  assign decoded = (status == ST_DECODED);

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      parse_status       <= status;
      sample_range       <= decoded ? dec_range : '0;
      sample_status_word <= decoded ? dec_status_word : '0;
      sample_timestamp   <= decoded ? dec_timestamp : '0;
    end
  end

`ifndef SYNTHESIS
  a_sample_fields_zero: assert property (@(posedge clk) disable iff (rst)
    (res_valid && parse_status != ST_DECODED) |->
      (sample_range == 0 && sample_status_word == 0 && sample_timestamp == 0))
    else $error("sample fields nonzero without a decoded frame");

  a_advance_fills_result: assert property (@(posedge clk) disable iff (rst)
    advance |=> res_valid)
    else $error("processed byte produced no result");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    !rx_ready |-> (s0_valid && res_valid && !res_ready))
    else $error("input stalled while a slot was free");

  a_store_write_on_step: assert property (@(posedge clk) disable iff (rst)
    store_wr.en |-> advance)
    else $error("payload store written without a byte step");
`endif

endmodule
